// ===== sv/rte_pkg.sv =====
// shared types, constants and the month table for rtc_time_to_epoch_seconds
// no dependencies; used by rte_decode, rte_mac and the top level
package rte_pkg;

    localparam logic [7:0]  REG_BCD_MODE     = 8'd0;
    localparam logic [7:0]  REG_HOUR_24_MODE = 8'd1;

    localparam logic [31:0] EPOCH_DAYS       = 32'd719162;
    localparam logic [16:0] SECS_PER_DAY     = 17'd86400;
    localparam logic [16:0] SECS_PER_HOUR    = 17'd3600;
    localparam logic [16:0] SECS_PER_MIN     = 17'd60;
    localparam logic [16:0] CENTURY_YEARS    = 17'd100;
    localparam logic [16:0] DAYS_PER_YEAR    = 17'd365;
    // floor(y / 100) == (y * 5243) >> 19 for every y below 2^15
    localparam logic [16:0] RECIP_100        = 17'd5243;
    localparam int          RECIP_SHIFT      = 19;

    typedef struct packed {
        logic [7:0] second;
        logic [7:0] minute;
        logic [7:0] hour;
        logic [7:0] day;
        logic [7:0] month;
        logic [7:0] year;
        logic [7:0] century;
    } rte_fields_t;

    typedef struct packed {
        logic        en;
        logic        use_acc;
        logic [31:0] base;
        logic [31:0] a;
        logic [16:0] b;
    } rte_mac_cmd_t;

    function automatic logic [8:0] days_before_month(input logic [3:0] m);
        logic [8:0] d;
        case (m)
            4'd2:    d = 9'd31;
            4'd3:    d = 9'd59;
            4'd4:    d = 9'd90;
            4'd5:    d = 9'd120;
            4'd6:    d = 9'd151;
            4'd7:    d = 9'd181;
            4'd8:    d = 9'd212;
            4'd9:    d = 9'd243;
            4'd10:   d = 9'd273;
            4'd11:   d = 9'd304;
            4'd12:   d = 9'd334;
            default: d = 9'd0;
        endcase
        return d;
    endfunction

endpackage

// ===== sv/rte_decode.sv =====
// byte decoder: bcd or binary, plus 12/24-hour handling of the hour byte
// depends on rte_pkg
module rte_decode (
    input  logic                 bcd_mode,
    input  logic                 hour_24_mode,
    input  rte_pkg::rte_fields_t raw,
    output rte_pkg::rte_fields_t dec
);

    function automatic logic [7:0] dec_byte(input logic [7:0] b, input logic bcd);
        logic [7:0] r;
        if (bcd) begin
            r = 8'(b[7:4] * 4'd10) + {4'd0, b[3:0]};
        end else begin
            r = b;
        end
        return r;
    endfunction

    logic [7:0] hour_12;

    assign hour_12 = dec_byte({1'b0, raw.hour[6:0]}, bcd_mode);

    always_comb begin
        dec.second  = dec_byte(raw.second, bcd_mode);
        dec.minute  = dec_byte(raw.minute, bcd_mode);
        dec.day     = dec_byte(raw.day, bcd_mode);
        dec.month   = dec_byte(raw.month, bcd_mode);
        dec.year    = dec_byte(raw.year, bcd_mode);
        dec.century = dec_byte(raw.century, bcd_mode);
        if (hour_24_mode) begin
            dec.hour = dec_byte(raw.hour, bcd_mode);
        end else if (raw.hour[7]) begin
            // pm: 12 pm stays 12
            dec.hour = (hour_12 == 8'd12) ? 8'd12 : hour_12 + 8'd12;
        end else begin
            // am: 12 am is midnight
            dec.hour = (hour_12 == 8'd12) ? 8'd0 : hour_12;
        end
    end

endmodule

// ===== sv/rte_mac.sv =====
// shared multiply-accumulate unit: acc = (acc or base) + a * b, modulo 2^32
// depends on rte_pkg
module rte_mac (
    input  logic                  aclk,
    input  rte_pkg::rte_mac_cmd_t cmd,
    output logic [31:0]           acc
);

    logic [48:0] prod;
    logic [31:0] acc_reg;
    logic [31:0] acc_next;

    assign prod     = {17'd0, cmd.a} * {32'd0, cmd.b};
    assign acc_next = (cmd.use_acc ? acc_reg : cmd.base) + prod[31:0];
    assign acc      = acc_reg;

    always_ff @(posedge aclk) begin
        if (cmd.en) begin
            acc_reg <= acc_next;
        end
    end

endmodule

// ===== sv/rtc_time_to_epoch_seconds.sv =====
// top level of the rtc snapshot to unix seconds converter
// depends on rte_pkg, rte_decode and rte_mac
//
// One item is a snapshot of the raw clock bytes; the result is the count of
// seconds since 1970-01-01 00:00:00 modulo 2^32. The bytes are decoded as the
// item is accepted, then a sequencer drives one shared 32x17 multiply-
// accumulate unit through 13 steps (full year, year / 100 by reciprocal,
// century check, the Gregorian day count term by term, then scaling by
// seconds per day, hour, minute and second). After the last step the result is
// loaded into the output register in the output state; the block waits there while
// an earlier result is still held and takes no new item until it is back in idle. s_ready is
// high only in the idle state; a result waiting in the output register does
// not hold off the next item, only the load of that item's own result.
// Configuration writes are always taken (cfg_ready is tied high); indexes
// other than bcd_mode and hour_24_mode are ignored.
module rtc_time_to_epoch_seconds (
    input  logic        aclk,
    input  logic        aresetn,

    input  logic        s_valid,
    output logic        s_ready,
    input  logic [7:0]  s_raw_second,
    input  logic [7:0]  s_raw_minute,
    input  logic [7:0]  s_raw_hour,
    input  logic [7:0]  s_raw_day,
    input  logic [7:0]  s_raw_month,
    input  logic [7:0]  s_raw_year,
    input  logic [7:0]  s_raw_century,

    output logic        m_valid,
    input  logic        m_ready,
    output logic [31:0] m_epoch_seconds,

    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [7:0]  cfg_index,
    input  logic        cfg_data
);

    // sequencer codes: idle, one per step of the shared unit, and output
    localparam logic [3:0] ST_IDLE = 4'd0;
    localparam logic [3:0] ST_YEAR = 4'd1;   // acc = century * 100 + year
    localparam logic [3:0] ST_QY   = 4'd2;   // acc = year * reciprocal of 100
    localparam logic [3:0] ST_CHK  = 4'd3;   // acc = (year / 100) * 100
    localparam logic [3:0] ST_D1   = 4'd4;   // acc = 365 * (year - 1) + q4
    localparam logic [3:0] ST_D2   = 4'd5;   // acc -= q100
    localparam logic [3:0] ST_D3   = 4'd6;   // acc += q400
    localparam logic [3:0] ST_D4   = 4'd7;   // acc += days before month, leap day
    localparam logic [3:0] ST_D5   = 4'd8;   // acc += day of month
    localparam logic [3:0] ST_D6   = 4'd9;   // acc -= epoch offset plus one
    localparam logic [3:0] ST_S1   = 4'd10;  // acc = days * 86400
    localparam logic [3:0] ST_S2   = 4'd11;  // acc += hour * 3600
    localparam logic [3:0] ST_S3   = 4'd12;  // acc += minute * 60
    localparam logic [3:0] ST_S4   = 4'd13;  // acc += second
    localparam logic [3:0] ST_OUT  = 4'd14;  // load output register

    logic [3:0]            state_reg, state_next;
    logic                  bcd_mode_reg;
    logic                  hour_24_mode_reg;
    rte_pkg::rte_fields_t  raw_in;
    rte_pkg::rte_fields_t  dec_in;
    rte_pkg::rte_fields_t  dec_reg;
    logic [14:0]           year_reg;     // full year
    logic [8:0]            qy_reg;       // full year / 100
    logic                  z_reg;        // full year is a multiple of 100
    logic                  m_valid_reg;
    logic [31:0]           m_data_reg;
    rte_pkg::rte_mac_cmd_t cmd;
    logic [31:0]           acc;

    logic                  s_fire;
    logic                  z_now;
    logic                  year_zero;
    logic [14:0]           q4;
    logic [8:0]            q100;
    logic [8:0]            q400;
    logic [3:0]            month_c;
    logic                  leap;
    logic                  leap_add;
    logic [9:0]            month_days;
    logic                  out_free;

    assign raw_in.second  = s_raw_second;
    assign raw_in.minute  = s_raw_minute;
    assign raw_in.hour    = s_raw_hour;
    assign raw_in.day     = s_raw_day;
    assign raw_in.month   = s_raw_month;
    assign raw_in.year    = s_raw_year;
    assign raw_in.century = s_raw_century;

    rte_decode u_decode (
        .bcd_mode     (bcd_mode_reg),
        .hour_24_mode (hour_24_mode_reg),
        .raw          (raw_in),
        .dec          (dec_in)
    );

    rte_mac u_mac (
        .aclk (aclk),
        .cmd  (cmd),
        .acc  (acc)
    );

    assign s_ready         = (state_reg == ST_IDLE);
    assign s_fire          = s_valid && s_ready;
    assign cfg_ready       = 1'b1;
    assign m_valid         = m_valid_reg;
    assign m_epoch_seconds = m_data_reg;
    assign out_free        = !m_valid_reg || m_ready;

    // century check against the product left by the check step
    assign z_now     = (acc == {17'd0, year_reg});
    assign year_zero = (year_reg == 15'd0);

    // quotients of (year - 1); year zero gives -1, whose quotients are all zero
    assign q4   = year_zero ? 15'd0 : 15'((year_reg - 15'd1) >> 2);
    assign q100 = year_zero ? 9'd0 : qy_reg - {8'd0, z_reg};
    assign q400 = q100 >> 2;

    // month zero acts as january, months past twelve as december
    always_comb begin
        if (dec_reg.month == 8'd0) begin
            month_c = 4'd1;
        end else if (dec_reg.month > 8'd12) begin
            month_c = 4'd12;
        end else begin
            month_c = dec_reg.month[3:0];
        end
    end

    // gregorian rule; multiple of 400 is a multiple of 100 with quotient % 4 == 0
    assign leap       = ((year_reg[1:0] == 2'b00) && !z_reg) || (z_reg && (qy_reg[1:0] == 2'b00));
    assign leap_add   = leap && (month_c > 4'd2);
    assign month_days = {1'b0, rte_pkg::days_before_month(month_c)} + {9'd0, leap_add};

    // command for the shared unit in each step
    always_comb begin
        cmd.en      = 1'b1;
        cmd.use_acc = 1'b1;
        cmd.base    = 32'd0;
        cmd.a       = 32'd0;
        cmd.b       = 17'd1;
        case (state_reg)
            ST_YEAR: begin
                cmd.use_acc = 1'b0;
                cmd.base    = {24'd0, dec_reg.year};
                cmd.a       = {24'd0, dec_reg.century};
                cmd.b       = rte_pkg::CENTURY_YEARS;
            end
            ST_QY: begin
                cmd.use_acc = 1'b0;
                cmd.a       = {17'd0, acc[14:0]};
                cmd.b       = rte_pkg::RECIP_100;
            end
            ST_CHK: begin
                cmd.use_acc = 1'b0;
                cmd.a       = {23'd0, acc[rte_pkg::RECIP_SHIFT +: 9]};
                cmd.b       = rte_pkg::CENTURY_YEARS;
            end
            ST_D1: begin
                cmd.use_acc = 1'b0;
                cmd.base    = {17'd0, q4};
                cmd.a       = {17'd0, year_reg} - 32'd1;
                cmd.b       = rte_pkg::DAYS_PER_YEAR;
            end
            ST_D2: begin
                cmd.a = 32'd0 - {23'd0, q100};
            end
            ST_D3: begin
                cmd.a = {23'd0, q400};
            end
            ST_D4: begin
                cmd.a = {22'd0, month_days};
            end
            ST_D5: begin
                cmd.a = {24'd0, dec_reg.day};
            end
            ST_D6: begin
                cmd.a = 32'd0 - rte_pkg::EPOCH_DAYS - 32'd1;
            end
            ST_S1: begin
                cmd.use_acc = 1'b0;
                cmd.a       = acc;
                cmd.b       = rte_pkg::SECS_PER_DAY;
            end
            ST_S2: begin
                cmd.a = {24'd0, dec_reg.hour};
                cmd.b = rte_pkg::SECS_PER_HOUR;
            end
            ST_S3: begin
                cmd.a = {24'd0, dec_reg.minute};
                cmd.b = rte_pkg::SECS_PER_MIN;
            end
            ST_S4: begin
                cmd.a = {24'd0, dec_reg.second};
            end
            default: begin
                cmd.en = 1'b0;
            end
        endcase
    end

    // sequencer
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (s_fire) begin
                    state_next = ST_YEAR;
                end
            end
            ST_OUT: begin
                if (out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = state_reg + 4'd1;
            end
        endcase
    end

    // control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg        <= ST_IDLE;
            bcd_mode_reg     <= 1'b1;
            hour_24_mode_reg <= 1'b1;
            m_valid_reg      <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (cfg_valid && cfg_ready) begin
                if (cfg_index == rte_pkg::REG_BCD_MODE) begin
                    bcd_mode_reg <= cfg_data;
                end else if (cfg_index == rte_pkg::REG_HOUR_24_MODE) begin
                    hour_24_mode_reg <= cfg_data;
                end
            end
            if (state_reg == ST_OUT && out_free) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // payload and working registers
    always_ff @(posedge aclk) begin
        if (s_fire) begin
            dec_reg <= dec_in;
        end
        if (state_reg == ST_QY) begin
            year_reg <= acc[14:0];
        end
        if (state_reg == ST_CHK) begin
            qy_reg <= acc[rte_pkg::RECIP_SHIFT +: 9];
        end
        if (state_reg == ST_D1) begin
            z_reg <= z_now;
        end
        if (state_reg == ST_OUT && out_free) begin
            m_data_reg <= acc;
        end
    end

endmodule

// ===== dv/rtc_time_to_epoch_seconds_tb.sv =====
// testbench for rtc_time_to_epoch_seconds: directed and random clock snapshots
// checked against an in-bench calendar predictor; depends on rte_pkg and the rtl
module rtc_time_to_epoch_seconds_tb;

    localparam int         WATCHDOG_LIMIT = 4000;
    localparam int         HOLD_CYCLES    = 300;
    localparam int         HOLD_AFTER     = 150;
    localparam int         IDLE_PERCENT   = 30;
    localparam int         DRAIN_CYCLES   = 20;
    localparam int         PHASE_ITEMS    = 100;
    // index that decodes to no register, the block must ignore it
    localparam logic [7:0] REG_UNUSED     = 8'd7;

    // scoreboard: own copy of the two mode bits and the queue of expected seconds
    class epoch_scoreboard;
        bit        bcd_mode     = 1'b1;
        bit        hour_24_mode = 1'b1;
        bit [31:0] epoch_q[$];
        int        mismatches   = 0;
        int        results_seen = 0;

        function void set_reg(logic [7:0] idx, bit val);
            if (idx == rte_pkg::REG_BCD_MODE) begin
                bcd_mode = val;
            end else if (idx == rte_pkg::REG_HOUR_24_MODE) begin
                hour_24_mode = val;
            end
        endfunction

        function bit [31:0] decode_byte(bit [7:0] b);
            if (bcd_mode) begin
                return 32'(b[7:4]) * 32'd10 + 32'(b[3:0]);
            end
            return 32'(b);
        endfunction

        function bit [31:0] decode_hour(bit [7:0] b);
            bit [31:0] h;
            if (hour_24_mode) begin
                return decode_byte(b);
            end
            h = decode_byte({1'b0, b[6:0]});
            if (b[7]) begin
                return (h == 32'd12) ? 32'd12 : h + 32'd12;
            end
            return (h == 32'd12) ? 32'd0 : h;
        endfunction

        function bit [31:0] month_offset(bit [31:0] m);
            case (m)
                32'd2:   return 32'd31;
                32'd3:   return 32'd59;
                32'd4:   return 32'd90;
                32'd5:   return 32'd120;
                32'd6:   return 32'd151;
                32'd7:   return 32'd181;
                32'd8:   return 32'd212;
                32'd9:   return 32'd243;
                32'd10:  return 32'd273;
                32'd11:  return 32'd304;
                32'd12:  return 32'd334;
                default: return 32'd0;
            endcase
        endfunction

        function bit [31:0] epoch_of(rte_pkg::rte_fields_t f);
            bit [31:0] yr;
            bit [31:0] mon;
            bit [31:0] total;
            bit        leap;
            int        y1;
            int        before_year;
            yr   = decode_byte(f.century) * 32'd100 + decode_byte(f.year);
            y1   = int'(yr) - 1;
            leap = ((yr % 4 == 0) && (yr % 100 != 0)) || (yr % 400 == 0);
            mon  = decode_byte(f.month);
            if (mon < 32'd1) mon = 32'd1;
            if (mon > 32'd12) mon = 32'd12;
            // signed on its own so year zero gives -365
            before_year = 365 * y1 + y1 / 4 - y1 / 100 + y1 / 400;
            total = month_offset(mon);
            if (leap && mon > 32'd2) total = total + 32'd1;
            total = total + decode_byte(f.day) - 32'd1;
            total = total + 32'(before_year);
            total = total - rte_pkg::EPOCH_DAYS;
            return total * 32'd86400 + decode_hour(f.hour) * 32'd3600
                 + decode_byte(f.minute) * 32'd60 + decode_byte(f.second);
        endfunction

        function void note_item(rte_pkg::rte_fields_t f);
            epoch_q.push_back(epoch_of(f));
        endfunction

        task report_mismatch(string what, bit [31:0] got, bit [31:0] want);
            $display("mismatch: %s got %0d expected %0d", what, got, want);
            mismatches++;
        endtask

        task check_result(bit [31:0] got);
            bit [31:0] want;
            results_seen++;
            if (epoch_q.size() == 0) begin
                report_mismatch("result with nothing pending", got, 32'd0);
            end else begin
                want = epoch_q.pop_front();
                if (got !== want) report_mismatch("epoch_seconds", got, want);
            end
        endtask
    endclass

    logic        aclk            = 1'b0;
    logic        aresetn         = 1'b0;
    logic        s_valid         = 1'b0;
    logic        s_ready;
    logic [7:0]  s_raw_second    = '0;
    logic [7:0]  s_raw_minute    = '0;
    logic [7:0]  s_raw_hour      = '0;
    logic [7:0]  s_raw_day       = '0;
    logic [7:0]  s_raw_month     = '0;
    logic [7:0]  s_raw_year      = '0;
    logic [7:0]  s_raw_century   = '0;
    logic        m_valid;
    logic        m_ready         = 1'b0;
    logic [31:0] m_epoch_seconds;
    logic        cfg_valid       = 1'b0;
    logic        cfg_ready;
    logic [7:0]  cfg_index       = '0;
    logic        cfg_data        = 1'b0;

    epoch_scoreboard sb = new();

    bit no_idle    = 1'b0;   // set for the idle-free stretch
    bit hold_done  = 1'b0;
    int hold_left  = 0;
    int items_sent = 0;
    int idle_count = 0;

    rtc_time_to_epoch_seconds i_dut (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_raw_second    (s_raw_second),
        .s_raw_minute    (s_raw_minute),
        .s_raw_hour      (s_raw_hour),
        .s_raw_day       (s_raw_day),
        .s_raw_month     (s_raw_month),
        .s_raw_year      (s_raw_year),
        .s_raw_century   (s_raw_century),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_epoch_seconds (m_epoch_seconds),
        .cfg_valid       (cfg_valid),
        .cfg_ready       (cfg_ready),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data)
    );

    always #4 aclk = ~aclk;

    // result side: random back-pressure, plus one long hold-off once enough
    // results have gone by so the block backs up and stalls its input
    always @(negedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else if (hold_left > 0) begin
            m_ready <= 1'b0;
            hold_left--;
        end else if (!hold_done && sb.results_seen >= HOLD_AFTER) begin
            hold_done = 1'b1;
            hold_left = HOLD_CYCLES - 1;
            m_ready <= 1'b0;
        end else begin
            m_ready <= no_idle || ($urandom_range(0, 99) >= IDLE_PERCENT);
        end
    end

    // every accepted result goes straight to the scoreboard
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) sb.check_result(m_epoch_seconds);
    end

    // watchdog: cycles in a row with no item moving on any channel
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready) || (cfg_valid && cfg_ready)) begin
            idle_count <= 0;
        end else if (idle_count >= WATCHDOG_LIMIT) begin
            $display("watchdog: no handshake for %0d cycles", idle_count);
            $display("TB_ERROR");
            $finish;
        end else begin
            idle_count <= idle_count + 1;
        end
    end

    // offer one snapshot, optionally after a short gap, and hold it until taken
    task send_item(rte_pkg::rte_fields_t f);
        int gap;
        gap = (!no_idle && $urandom_range(0, 99) < IDLE_PERCENT) ? $urandom_range(1, 3) : 0;
        @(negedge aclk);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_valid       <= 1'b1;
        s_raw_second  <= f.second;
        s_raw_minute  <= f.minute;
        s_raw_hour    <= f.hour;
        s_raw_day     <= f.day;
        s_raw_month   <= f.month;
        s_raw_year    <= f.year;
        s_raw_century <= f.century;
        do @(posedge aclk); while (!s_ready);
        sb.note_item(f);
        items_sent++;
    endtask

    task send_raw(bit [7:0] sec, bit [7:0] mnt, bit [7:0] hr, bit [7:0] dy,
                  bit [7:0] mon, bit [7:0] yr, bit [7:0] cen);
        rte_pkg::rte_fields_t f;
        f = '{second: sec, minute: mnt, hour: hr, day: dy, month: mon,
              year: yr, century: cen};
        send_item(f);
    endtask

    task end_offer();
        @(negedge aclk);
        s_valid <= 1'b0;
    endtask

    task write_reg(logic [7:0] idx, bit val);
        @(negedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(posedge aclk); while (!cfg_ready);
        sb.set_reg(idx, val);
        @(negedge aclk);
        cfg_valid <= 1'b0;
    endtask

    // wait for every pending result, then a margin before touching registers
    task wait_drained();
        while (sb.epoch_q.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    // stop offering first so the last snapshot is not taken a second time
    task set_modes(bit bcd, bit h24);
        end_offer();
        wait_drained();
        write_reg(rte_pkg::REG_BCD_MODE, bcd);
        write_reg(rte_pkg::REG_HOUR_24_MODE, h24);
    endtask

    function bit [7:0] encode(int v, bit bcd);
        return bcd ? 8'(((v / 10) << 4) | (v % 10)) : 8'(v);
    endfunction

    // mostly calendar-correct snapshots in the current modes, the rest raw noise
    function rte_pkg::rte_fields_t random_item();
        rte_pkg::rte_fields_t f;
        bit                   bcd;
        int                   hr;
        bcd = sb.bcd_mode;
        if ($urandom_range(0, 99) < 25) begin
            f = rte_pkg::rte_fields_t'(56'({$urandom(), $urandom()}));
        end else begin
            f.second  = encode($urandom_range(0, 59), bcd);
            f.minute  = encode($urandom_range(0, 59), bcd);
            f.day     = encode($urandom_range(1, 31), bcd);
            f.month   = encode($urandom_range(1, 12), bcd);
            f.year    = encode($urandom_range(0, 99), bcd);
            f.century = encode($urandom_range(0, 9) == 0 ? $urandom_range(0, 99)
                                                         : $urandom_range(19, 21), bcd);
            if (sb.hour_24_mode) begin
                f.hour = encode($urandom_range(0, 23), bcd);
            end else begin
                hr     = $urandom_range(1, 12);
                f.hour = encode(hr, bcd) | (8'($urandom_range(0, 1)) << 7);
            end
        end
        return f;
    endfunction

    initial begin
        repeat (6) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // reset modes written back explicitly, plus a write the block ignores
        write_reg(rte_pkg::REG_BCD_MODE, 1'b1);
        write_reg(rte_pkg::REG_HOUR_24_MODE, 1'b1);
        write_reg(REG_UNUSED, 1'b0);

        // bcd, 24-hour: epoch, 2038 rollover, leap rules, bad nibbles, month
        // zero and above twelve, day zero, year zero, hour with bit 7 set
        send_raw(8'h00, 8'h00, 8'h00, 8'h01, 8'h01, 8'h70, 8'h19);
        send_raw(8'h07, 8'h14, 8'h03, 8'h19, 8'h01, 8'h38, 8'h20);
        send_raw(8'h59, 8'h59, 8'h23, 8'h29, 8'h03, 8'h00, 8'h20);
        send_raw(8'h00, 8'h00, 8'h00, 8'h01, 8'h03, 8'h00, 8'h21);
        send_raw(8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF);
        send_raw(8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00);
        send_raw(8'h30, 8'h30, 8'h12, 8'h15, 8'h00, 8'h24, 8'h20);
        send_raw(8'h30, 8'h30, 8'h12, 8'h15, 8'h13, 8'h24, 8'h20);
        send_raw(8'h00, 8'h00, 8'h99, 8'h01, 8'h06, 8'h99, 8'h19);

        // binary, 24-hour: all ones, just before the epoch, month way over
        set_modes(1'b0, 1'b1);
        send_raw(8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF);
        send_raw(8'd59, 8'd59, 8'd23, 8'd31, 8'd12, 8'd69, 8'd19);
        send_raw(8'd0, 8'd0, 8'd0, 8'd255, 8'd200, 8'd0, 8'd20);
        send_raw(8'd1, 8'd2, 8'd3, 8'd0, 8'd2, 8'd0, 8'd0);

        // bcd, 12-hour: 12 am, 12 pm, 1 pm, 1 am, all ones
        set_modes(1'b1, 1'b0);
        send_raw(8'h00, 8'h00, 8'h12, 8'h01, 8'h01, 8'h70, 8'h19);
        send_raw(8'h00, 8'h00, 8'h92, 8'h01, 8'h01, 8'h70, 8'h19);
        send_raw(8'h00, 8'h00, 8'h81, 8'h01, 8'h01, 8'h70, 8'h19);
        send_raw(8'h00, 8'h00, 8'h01, 8'h01, 8'h01, 8'h70, 8'h19);
        send_raw(8'h00, 8'h00, 8'hFF, 8'h01, 8'h01, 8'h70, 8'h19);

        // binary, 12-hour
        set_modes(1'b0, 1'b0);
        send_raw(8'd0, 8'd0, 8'h0C, 8'd1, 8'd1, 8'd70, 8'd19);
        send_raw(8'd0, 8'd0, 8'h8C, 8'd1, 8'd1, 8'd70, 8'd19);
        send_raw(8'd0, 8'd0, 8'h8B, 8'd1, 8'd1, 8'd70, 8'd19);
        send_raw(8'd0, 8'd0, 8'hFF, 8'd1, 8'd1, 8'd70, 8'd19);
        end_offer();

        // random phases through every mode pair; the third runs without idling
        for (int phase = 0; phase < 5; phase++) begin
            case (phase)
                0:       set_modes(1'b1, 1'b1);
                1:       set_modes(1'b0, 1'b1);
                2:       set_modes(1'b1, 1'b0);
                3:       set_modes(1'b0, 1'b0);
                default: set_modes(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
            endcase
            no_idle = (phase == 2);
            for (int n = 0; n < PHASE_ITEMS; n++) send_item(random_item());
            no_idle = 1'b0;
            end_offer();
        end

        wait_drained();
        $display("run covered %0d snapshots over all bcd and 12/24-hour mode pairs,",
                 items_sent);
        $display("with %0d results checked and one long output hold-off", sb.results_seen);
        if (sb.mismatches == 0 && sb.epoch_q.size() == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule
